FILE: design/binary_min_heap_queue_macros.svh
// ============================================================================
// binary_min_heap_queue_macros.svh
// Assertion macros used by the heap queue top level
// ============================================================================
`ifndef BINARY_MIN_HEAP_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_MACROS_SVH

// same-cycle implication, checked outside reset
`define BMHQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// next-cycle implication, checked outside reset
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

FILE: design/bmhq_pkg.sv
// ============================================================================
// bmhq_pkg
// Constants, codes and controller/datapath interface types of the heap queue
// ============================================================================
package bmhq_pkg;

    localparam int HEAP_DEPTH = 512;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_W      = ADDR_W + 2;
    localparam int KEY_W      = 32;
    localparam int HDL_W      = 16;
    localparam int ENTRY_W    = KEY_W + HDL_W;
    localparam int FILL_W     = 10;
    localparam int STAT_W     = 2;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 64;
    localparam int M_PAD_W    = M_DATA_W - KEY_W - HDL_W - FILL_W;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        RD_ROOT   = 3'd0,
        RD_PARENT = 3'd1,
        RD_LAST   = 3'd2,
        RD_LEFT   = 3'd3,
        RD_RIGHT  = 3'd4
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_CUR   = 2'd0,
        WR_RDATA = 2'd1,
        WR_BEST  = 2'd2
    } wr_sel_t;

    typedef enum logic [2:0] {
        HOLE_HOLD   = 3'd0,
        HOLE_COUNT  = 3'd1,
        HOLE_ZERO   = 3'd2,
        HOLE_PARENT = 3'd3,
        HOLE_BEST   = 3'd4
    } hole_sel_t;

    typedef struct packed {
        logic              accept;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              rd_en;
        rd_sel_t           rd_sel;
        logic              wr_en;
        wr_sel_t           wr_sel;
        hole_sel_t         hole_sel;
        logic              take_root;
        logic              take_last;
        logic              take_left;
        logic              take_right;
        logic              load_out;
        logic [STAT_W-1:0] out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic at_root;
        logic up_swap;
        logic left_ok;
        logic right_ok;
        logic best_child;
    } dp_stat_t;

endpackage

FILE: design/bmhq_datapath.sv
// ============================================================================
// bmhq_datapath
// Heap store, entry count, hole pointer, compare logic and result register
// ============================================================================
module bmhq_datapath
    import bmhq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic [KEY_W-1:0]  in_key,
    input  logic [HDL_W-1:0]  in_handle,
    output dp_stat_t          stat,
    output logic [STAT_W-1:0] out_status,
    output logic [KEY_W-1:0]  out_key,
    output logic [HDL_W-1:0]  out_handle,
    output logic [FILL_W-1:0] fill
);

    logic [ENTRY_W-1:0] mem [HEAP_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  hole_reg, hole_next;
    logic [KEY_W-1:0]   cur_key_reg, best_key_reg, res_key_reg;
    logic [HDL_W-1:0]   cur_hdl_reg, best_hdl_reg, res_hdl_reg;
    logic [ADDR_W-1:0]  best_idx_reg;
    logic               best_child_reg;

    logic [STAT_W-1:0]  out_status_reg;
    logic [KEY_W-1:0]   out_key_reg;
    logic [HDL_W-1:0]   out_hdl_reg;
    logic [FILL_W-1:0]  fill_reg;

    logic [IDX_W-1:0]   left_idx, right_idx, count_ext;
    logic [ADDR_W-1:0]  parent_idx, rd_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [KEY_W-1:0]   rd_key;
    logic [HDL_W-1:0]   rd_hdl;

    assign rd_key = rdata_reg[ENTRY_W-1 -: KEY_W];
    assign rd_hdl = rdata_reg[HDL_W-1:0];

    assign left_idx   = {1'b0, hole_reg, 1'b1};
    assign right_idx  = left_idx + IDX_W'(1);
    assign count_ext  = IDX_W'(count_reg);
    assign parent_idx = ADDR_W'((hole_reg - ADDR_W'(1)) >> 1);

    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CNT_W'(HEAP_DEPTH));
    assign stat.at_root    = (hole_reg == '0);
    assign stat.up_swap    = (rd_key > cur_key_reg);
    assign stat.left_ok    = (left_idx < count_ext);
    assign stat.right_ok   = (right_idx < count_ext);
    assign stat.best_child = best_child_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ROOT:   rd_addr = '0;
            RD_PARENT: rd_addr = parent_idx;
            RD_LAST:   rd_addr = ADDR_W'(count_reg - CNT_W'(1));
            RD_LEFT:   rd_addr = left_idx[ADDR_W-1:0];
            RD_RIGHT:  rd_addr = right_idx[ADDR_W-1:0];
            default:   rd_addr = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_CUR:   wr_data = {cur_key_reg, cur_hdl_reg};
            WR_RDATA: wr_data = rdata_reg;
            WR_BEST:  wr_data = {best_key_reg, best_hdl_reg};
            default:  wr_data = {cur_key_reg, cur_hdl_reg};
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        case (cmd.hole_sel)
            HOLE_HOLD:   hole_next = hole_reg;
            HOLE_COUNT:  hole_next = count_reg[ADDR_W-1:0];
            HOLE_ZERO:   hole_next = '0;
            HOLE_PARENT: hole_next = parent_idx;
            HOLE_BEST:   hole_next = best_idx_reg;
            default:     hole_next = hole_reg;
        endcase
    end

    // hole always receives the write, so the store never sees a full swap
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[hole_reg] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            hole_reg       <= '0;
            best_child_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            hole_reg  <= hole_next;
            if (cmd.take_left)
            begin
                best_child_reg <= (rd_key < cur_key_reg);
            end
            else if (cmd.take_right && (rd_key < best_key_reg))
            begin
                best_child_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_key_reg <= in_key;
            cur_hdl_reg <= in_handle;
            res_key_reg <= '0;
            res_hdl_reg <= '0;
        end
        if (cmd.take_root)
        begin
            res_key_reg <= rd_key;
            res_hdl_reg <= rd_hdl;
        end
        if (cmd.take_last)
        begin
            cur_key_reg <= rd_key;
            cur_hdl_reg <= rd_hdl;
        end
        // left child wins only if strictly smaller than the moving entry
        if (cmd.take_left)
        begin
            if (rd_key < cur_key_reg)
            begin
                best_key_reg <= rd_key;
                best_hdl_reg <= rd_hdl;
                best_idx_reg <= left_idx[ADDR_W-1:0];
            end
            else
            begin
                best_key_reg <= cur_key_reg;
                best_hdl_reg <= cur_hdl_reg;
                best_idx_reg <= hole_reg;
            end
        end
        else if (cmd.take_right && (rd_key < best_key_reg))
        begin
            best_key_reg <= rd_key;
            best_hdl_reg <= rd_hdl;
            best_idx_reg <= right_idx[ADDR_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.out_status;
            out_key_reg    <= res_key_reg;
            out_hdl_reg    <= res_hdl_reg;
            fill_reg       <= FILL_W'(count_reg);
        end
    end

    assign out_status = out_status_reg;
    assign out_key    = out_key_reg;
    assign out_handle = out_hdl_reg;
    assign fill       = fill_reg;

endmodule

FILE: design/bmhq_ctrl.sv
// ============================================================================
// bmhq_ctrl
// Sequencer for insert sift-up and pop sift-down, plus output handshake
// ============================================================================
module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_opcode,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_UP_CHK   = 10'b00_0000_0010,
        S_UP_CMP   = 10'b00_0000_0100,
        S_POP_ROOT = 10'b00_0000_1000,
        S_POP_LAST = 10'b00_0001_0000,
        S_DN_L     = 10'b00_0010_0000,
        S_DN_R     = 10'b00_0100_0000,
        S_DN_RCMP  = 10'b00_1000_0000,
        S_DN_MOVE  = 10'b01_0000_0000,
        S_RESP     = 10'b10_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept  = 1'b1;
                    status_next = ST_DONE;
                    if (in_opcode == OP_INSERT)
                    begin
                        if (stat.full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            cmd.hole_sel = HOLE_COUNT;
                            cmd.cnt_inc  = 1'b1;
                            state_next   = S_UP_CHK;
                        end
                    end
                    else if (stat.empty)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_ROOT;
                        state_next = S_POP_ROOT;
                    end
                end
            end
            S_UP_CHK:
            begin
                if (stat.at_root)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_CUR;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                cmd.wr_en = 1'b1;
                // parent moves down into the hole when strictly greater
                if (stat.up_swap)
                begin
                    cmd.wr_sel   = WR_RDATA;
                    cmd.hole_sel = HOLE_PARENT;
                    state_next   = S_UP_CHK;
                end
                else
                begin
                    cmd.wr_sel = WR_CUR;
                    state_next = S_RESP;
                end
            end
            S_POP_ROOT:
            begin
                cmd.take_root = 1'b1;
                cmd.cnt_dec   = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = RD_LAST;
                state_next    = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                cmd.take_last = 1'b1;
                cmd.hole_sel  = HOLE_ZERO;
                state_next    = stat.empty ? S_RESP : S_DN_L;
            end
            S_DN_L:
            begin
                if (stat.left_ok)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LEFT;
                    state_next = S_DN_R;
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_CUR;
                    state_next = S_RESP;
                end
            end
            S_DN_R:
            begin
                cmd.take_left = 1'b1;
                if (stat.right_ok)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_RIGHT;
                    state_next = S_DN_RCMP;
                end
                else
                begin
                    state_next = S_DN_MOVE;
                end
            end
            S_DN_RCMP:
            begin
                cmd.take_right = 1'b1;
                state_next     = S_DN_MOVE;
            end
            S_DN_MOVE:
            begin
                cmd.wr_en = 1'b1;
                if (stat.best_child)
                begin
                    cmd.wr_sel   = WR_BEST;
                    cmd.hole_sel = HOLE_BEST;
                    state_next   = S_DN_L;
                end
                else
                begin
                    cmd.wr_sel = WR_CUR;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_status = status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/binary_min_heap_queue.sv
// Insert opens a hole at the end and climbs through S_UP_CHK and S_UP_CMP per
// level while the parent is strictly greater; pop reads the root and the last
// entry, then descends through S_DN_L, S_DN_R, S_DN_RCMP (when a right child
// exists) and S_DN_MOVE per level. Empty pop or full insert goes straight to
// S_RESP. One request at a time, paced by the levels walked and the single
// store read port. Reset clears the count and result valid, not the store.
// ============================================================================
// binary_min_heap_queue
// Binary min-heap priority queue with insert and pop-minimum requests
// ============================================================================
`include "binary_min_heap_queue_macros.svh"

module binary_min_heap_queue
    import bmhq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key[31:0], handle[47:32]
    input  logic [0:0]          s_tuser,   // opcode[0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_key[31:0], out_handle[47:32], fill[57:48]
    output logic [STAT_W-1:0]   m_tuser    // status[1:0]
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [STAT_W-1:0] out_status;
    logic [KEY_W-1:0]  out_key;
    logic [HDL_W-1:0]  out_handle;
    logic [FILL_W-1:0] fill;

    bmhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_opcode (s_tuser[0]),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bmhq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_key     (s_tdata[KEY_W-1:0]),
        .in_handle  (s_tdata[KEY_W +: HDL_W]),
        .stat       (stat),
        .out_status (out_status),
        .out_key    (out_key),
        .out_handle (out_handle),
        .fill       (fill)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, fill, out_handle, out_key};
    assign m_tuser = out_status;

    `BMHQ_ASSERT_NEXT(a_busy_after_request, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `BMHQ_ASSERT_IMP(a_fill_bound, clk, rst_n, m_tvalid, 32'(fill) <= HEAP_DEPTH)
    `BMHQ_ASSERT_IMP(a_error_zero_payload, clk, rst_n, m_tvalid && (out_status != ST_DONE), (out_key == '0) && (out_handle == '0))
    `BMHQ_ASSERT_IMP(a_full_at_depth, clk, rst_n, m_tvalid && (out_status == ST_FULL), 32'(fill) == HEAP_DEPTH)

endmodule
